>>> rtl/core/sde_pkg.sv
package sde_pkg;

    localparam int DEF_MAX_BASE  = 16;
    localparam int DEF_NUM_WIDTH = 32;

    localparam int NUMBER_W    = 32;
    localparam int SYMBOL_W    = 7;
    localparam int BASE_LEN_W  = 5;
    localparam int SYMBOLS_W   = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Quotient bits resolved per cycle by the back end's divider.
    localparam int STEP_BITS   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_FIRST = 8'd32;
    localparam logic [7:0] SYM_END   = 8'd127;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BASE_LEN_W-1:0] BASE_LEN_RST     = 5'd10;
    localparam logic [SYMBOLS_W-1:0]  SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [SYMBOLS_W-1:0]  SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    typedef struct packed {
        logic [BASE_LEN_W-1:0] base_len;
        logic [SYMBOLS_W-1:0]  symbols_low;
        logic [SYMBOLS_W-1:0]  symbols_high;
    } sde_cfg_t;

    function automatic logic [7:0] sym_at(sde_cfg_t cfg, logic [3:0] idx);
        logic [7:0] s;
        if (idx[3]) begin
            s = cfg.symbols_high[{idx[2:0], 3'b000} +: 8];
        end else begin
            s = cfg.symbols_low[{idx[2:0], 3'b000} +: 8];
        end
        return s;
    endfunction

endpackage

>>> rtl/core/signed_radix_digit_emitter.sv
// Prints a signed number as text in a configurable radix, one symbol per output item, most
// significant digit first, with a leading '-' for negative values and last_symbol set on the
// final symbol. The radix is base_len and digit d is drawn from byte d of symbols_low and
// symbols_high; reset gives decimal "0123456789". With an invalid alphabet (radix below 2 or
// above MAX_BASE, a symbol outside 32..126, '+' or '-', or a repeated symbol) each number is
// taken as soon as the queue has room and is dropped, and nothing is written. The back end's
// divider resolves eight quotient bits per cycle and produces the digits least significant
// first, and the symbols then leave one per cycle while the output is ready. A two-entry
// queue lets the next numbers be taken while one is being printed. Configuration registers
// may only be written while idle.
module signed_radix_digit_emitter #(
    parameter int MAX_BASE  = sde_pkg::DEF_MAX_BASE,
    parameter int NUM_WIDTH = sde_pkg::DEF_NUM_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sde_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sde_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sde_pkg::NUMBER_W-1:0] s_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sde_pkg::SYMBOL_W-1:0]        m_out_symbol,
    output logic                                m_last_symbol
);
    import sde_pkg::*;

    logic [BASE_LEN_W-1:0] base_len_reg;
    logic [SYMBOLS_W-1:0]  symbols_low_reg;
    logic [SYMBOLS_W-1:0]  symbols_high_reg;
    sde_cfg_t              cfg;

    logic                  push_valid;
    logic                  push_ready;
    logic [NUM_WIDTH:0]    push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [NUM_WIDTH:0]    pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg     <= BASE_LEN_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BASE_LEN:     base_len_reg     <= cfg_data[BASE_LEN_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.base_len     = base_len_reg;
    assign cfg.symbols_low  = symbols_low_reg;
    assign cfg.symbols_high = symbols_high_reg;

    sde_front #(
        .MAX_BASE  (MAX_BASE),
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_number   (s_number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sde_queue #(
        .WIDTH (NUM_WIDTH + 1)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sde_back #(
        .MAX_BASE  (MAX_BASE),
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_symbol  (m_out_symbol),
        .m_last_symbol (m_last_symbol)
    );

endmodule

>>> rtl/core/sde_front.sv
module sde_front #(
    parameter int MAX_BASE  = 16,
    parameter int NUM_WIDTH = 32
) (
    input  sde_pkg::sde_cfg_t                cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [sde_pkg::NUMBER_W-1:0] s_number,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic [NUM_WIDTH:0]               push_data
);
    import sde_pkg::*;

    logic                 alpha_ok;
    logic [NUM_WIDTH-1:0] value;
    logic [NUM_WIDTH-1:0] mag;
    logic                 neg;

    // The alphabet check is a flat array of independent compares.
    always_comb begin
        logic [7:0] c;
        c = '0;
        alpha_ok = (cfg.base_len >= 5'd2) && (cfg.base_len <= 5'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++) begin
            c = sym_at(cfg, 4'(i));
            if (5'(i) < cfg.base_len) begin
                if (c == SYM_PLUS || c == SYM_MINUS || c < SYM_FIRST || c >= SYM_END) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_BASE; j++) begin
                    if (5'(j) < cfg.base_len && sym_at(cfg, 4'(j)) == c) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // The magnitude of the most negative value still fits as an unsigned word.
    assign value = s_number[NUM_WIDTH-1:0];
    assign neg   = value[NUM_WIDTH-1];
    assign mag   = neg ? (NUM_WIDTH'(0) - value) : value;

    // An item that meets an invalid alphabet is taken and dropped.
    assign s_ready    = push_ready;
    assign push_valid = s_valid && alpha_ok;
    assign push_data  = {neg, mag};

endmodule

>>> rtl/core/sde_queue.sv
module sde_queue #(
    parameter int WIDTH = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import sde_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/sde_back.sv
module sde_back #(
    parameter int MAX_BASE  = 16,
    parameter int NUM_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sde_pkg::sde_cfg_t                 cfg,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  logic [NUM_WIDTH:0]                pop_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sde_pkg::SYMBOL_W-1:0]      m_out_symbol,
    output logic                              m_last_symbol
);
    import sde_pkg::*;

    localparam int DIV_CYC = (NUM_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W   = DIV_CYC * STEP_BITS;
    localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int DIG_W   = $clog2(MAX_BASE);
    localparam int RAD_W   = $clog2(MAX_BASE + 1);
    localparam int SP_W    = $clog2(NUM_WIDTH + 1);
    localparam int IDX_W   = $clog2(NUM_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [PAD_W-1:0]      q_reg;
    logic [DIG_W-1:0]      rem_reg;
    logic [CYC_W-1:0]      cyc_reg;
    logic [SP_W-1:0]       sp_reg;
    logic                  neg_reg;
    logic                  out_valid_reg;
    logic [SYMBOL_W-1:0]   sym_reg;
    logic                  last_reg;

    logic [DIG_W-1:0]      digit_mem [NUM_WIDTH];

    logic [RAD_W-1:0]      radix;
    logic [DIG_W-1:0]      rem_next;
    logic [PAD_W-1:0]      q_next;
    logic [STEP_BITS-1:0]  qbits;
    logic                  slot_free;
    logic                  load_sym;
    logic                  cyc_last;
    logic                  push_digit;
    logic [IDX_W-1:0]      top_idx;
    logic [7:0]            top_sym;

    assign radix     = cfg.base_len[RAD_W-1:0];
    assign slot_free = !out_valid_reg || m_ready;
    assign load_sym  = slot_free && (state_reg == ST_SIGN || state_reg == ST_EMIT);
    assign cyc_last  = (cyc_reg == CYC_W'(DIV_CYC - 1));
    assign pop_ready = (state_reg == ST_IDLE);
    assign push_digit = (state_reg == ST_DIV) && cyc_last;
    assign top_idx   = IDX_W'(sp_reg - 1'b1);
    assign top_sym   = sym_at(cfg, 4'(digit_mem[top_idx]));

    // Long division of the word by the radix, STEP_BITS quotient bits per cycle.
    // Quotient bits refill the word from the bottom as the dividend shifts out.
    always_comb begin
        logic [DIG_W:0] t;
        t        = '0;
        rem_next = rem_reg;
        qbits    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {rem_next, q_reg[PAD_W-1-i]};
            if (t >= (DIG_W + 1)'(radix)) begin
                t = t - (DIG_W + 1)'(radix);
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            rem_next = t[DIG_W-1:0];
        end
        q_next = (q_reg << STEP_BITS) | PAD_W'(qbits);
    end

    always_ff @(posedge aclk) begin
        if (push_digit) begin
            digit_mem[sp_reg[IDX_W-1:0]] <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cyc_reg       <= '0;
            sp_reg        <= '0;
            neg_reg       <= 1'b0;
            rem_reg       <= '0;
            q_reg         <= '0;
            sym_reg       <= '0;
            last_reg      <= 1'b0;
        end else begin
            if (m_ready && !load_sym) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        q_reg     <= PAD_W'(pop_data[NUM_WIDTH-1:0]);
                        neg_reg   <= pop_data[NUM_WIDTH];
                        rem_reg   <= '0;
                        cyc_reg   <= '0;
                        sp_reg    <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    q_reg <= q_next;
                    if (cyc_last) begin
                        rem_reg <= '0;
                        cyc_reg <= '0;
                        sp_reg  <= sp_reg + 1'b1;
                        if (q_next == '0) begin
                            state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                        end
                    end else begin
                        rem_reg <= rem_next;
                        cyc_reg <= cyc_reg + 1'b1;
                    end
                end
                ST_SIGN: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        sym_reg       <= SYM_MINUS[SYMBOL_W-1:0];
                        last_reg      <= 1'b0;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        sym_reg       <= top_sym[SYMBOL_W-1:0];
                        last_reg      <= (sp_reg == SP_W'(1));
                        sp_reg        <= sp_reg - 1'b1;
                        if (sp_reg == SP_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_symbol  = sym_reg;
    assign m_last_symbol = last_reg;

    // Emission always has at least one stored digit to draw from.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (sp_reg != '0))
        else $error("digit stack empty while emitting");

    // Loading the final digit closes the text and frees the back end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && slot_free && sp_reg == SP_W'(1))
        |=> (state_reg == ST_IDLE && m_valid && m_last_symbol))
        else $error("final symbol not flagged or back end not released");

    // Between numbers, any symbol still waiting must be the end of a text.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && out_valid_reg) |-> last_reg)
        else $error("unfinished text left in output register");

    // The division counter never runs past the last step of a digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cyc_reg <= CYC_W'(DIV_CYC - 1)))
        else $error("division step counter out of range");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sde_pkg::*;

    localparam int    CLK_PERIOD     = 12;
    localparam int    RESET_CYCLES   = 6;
    localparam int    DRAIN_CYCLES   = 300;
    localparam int    STALL_CYCLES   = 500;
    localparam int    REPORT_LIMIT   = 10;
    localparam longint TIMEOUT_CYCLES = 1_500_000;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    // Sixteen digit symbols "0123456789ABCDEF", digit 0 in the low byte.
    localparam logic [127:0] HEX_SYMBOLS = 128'h4645_4443_4241_3938_3736_3534_3332_3130;

    typedef struct {
        logic [SYMBOL_W-1:0] code;
        logic                is_last;
    } symbol_t;

    typedef enum {FLAW_NONE, FLAW_BAD_SYMBOL, FLAW_REPEAT, FLAW_BAD_LENGTH} flaw_t;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [NUMBER_W-1:0]    s_number  = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [SYMBOL_W-1:0]           m_out_symbol;
    logic                          m_last_symbol;

    // Shadow copy of the configuration registers.
    logic [BASE_LEN_W-1:0] radix_reg   = BASE_LEN_RST;
    logic [SYMBOLS_W-1:0]  symbols_lo  = SYMBOLS_LOW_RST;
    logic [SYMBOLS_W-1:0]  symbols_hi  = SYMBOLS_HIGH_RST;

    symbol_t pending_text[$];

    int  send_idle_pct     = 0;
    int  recv_idle_pct     = 0;
    int  stall_cycles_left = 0;
    logic stall_active     = 1'b0;

    int failures        = 0;
    int items_sent      = 0;
    int printed_items   = 0;
    int silent_items    = 0;
    int negative_items  = 0;
    int symbols_checked = 0;
    int alphabets_seen  = 0;
    int blocked_cycles  = 0;

    signed_radix_digit_emitter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_number      (s_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_symbol  (m_out_symbol),
        .m_last_symbol (m_last_symbol)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d symbols still outstanding", pending_text.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic void log_failure(string what);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("%0t ERROR %s", $realtime, what);
        end
    endfunction

    function automatic logic [7:0] glyph(logic [3:0] digit);
        logic [127:0] all_symbols;
        all_symbols = {symbols_hi, symbols_lo};
        return all_symbols[digit * 8 +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int n;
        logic [7:0] c;
        n = int'(radix_reg);
        if (n < 2 || n > DEF_MAX_BASE) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            c = glyph(4'(i));
            if (c == SYM_PLUS || c == SYM_MINUS || c < SYM_FIRST || c >= SYM_END) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (glyph(4'(j)) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Works out the text of one accepted number and queues its symbols.
    function automatic void predict_text(logic [NUMBER_W-1:0] num);
        logic [NUMBER_W-1:0] mag;
        logic [NUMBER_W-1:0] radix;
        logic [NUMBER_W-1:0] rem;
        logic [3:0]          digits[$];
        logic [7:0]          g;
        symbol_t             item;
        if (!alphabet_valid()) begin
            silent_items++;
            return;
        end
        printed_items++;
        radix = NUMBER_W'(radix_reg);
        // The magnitude of the most negative value still fits in 32 unsigned bits.
        mag = num[NUMBER_W-1] ? (~num + 1'b1) : num;
        do begin
            rem = mag % radix;
            digits.push_front(rem[3:0]);
            mag = mag / radix;
        end while (mag != 0);
        if (num[NUMBER_W-1]) begin
            negative_items++;
            item.code    = SYM_MINUS[SYMBOL_W-1:0];
            item.is_last = 1'b0;
            pending_text.push_back(item);
        end
        foreach (digits[k]) begin
            g            = glyph(digits[k]);
            item.code    = g[SYMBOL_W-1:0];
            item.is_last = (k == digits.size() - 1);
            pending_text.push_back(item);
        end
    endfunction

    // Result side: checks every accepted symbol and drives m_ready for the next cycle.
    initial begin : symbol_checker
        symbol_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                symbols_checked++;
                if (pending_text.size() == 0) begin
                    log_failure($sformatf("unexpected symbol %0d last %0b",
                                          m_out_symbol, m_last_symbol));
                end else begin
                    want = pending_text.pop_front();
                    if (m_out_symbol !== want.code || m_last_symbol !== want.is_last) begin
                        log_failure($sformatf("symbol %0d last %0b, expected %0d last %0b",
                                              m_out_symbol, m_last_symbol,
                                              want.code, want.is_last));
                    end
                end
            end
            if (stall_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Counts down a long output stall and notes how long the input is held off meanwhile.
    initial begin : stall_counter
        forever begin
            @(posedge aclk);
            if (stall_active && s_valid && !s_ready) begin
                blocked_cycles++;
            end
            if (stall_cycles_left > 0) begin
                stall_cycles_left--;
                stall_active <= 1'b1;
            end else begin
                stall_active <= 1'b0;
            end
        end
    end

    task automatic send_number(input logic [NUMBER_W-1:0] num);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid  <= 1'b1;
        s_number <= num;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_text(num);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data,
                                  input bit close_burst);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BASE_LEN:     radix_reg  = data[BASE_LEN_W-1:0];
            REG_SYMBOLS_LOW:  symbols_lo = data;
            REG_SYMBOLS_HIGH: symbols_hi = data;
            default: ;
        endcase
        if (close_burst) begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic load_alphabet(input logic [CFG_DATA_W-1:0] len_word,
                                 input logic [127:0] syms);
        write_register(REG_BASE_LEN, len_word, 1'b0);
        write_register(REG_SYMBOLS_LOW, syms[63:0], 1'b0);
        write_register(REG_SYMBOLS_HIGH, syms[127:64], 1'b1);
        alphabets_seen++;
    endtask

    // The block must be idle before any register write. An item under an invalid alphabet
    // leaves no trace, so a fixed drain follows the last expected symbol.
    task automatic hold_until_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_text.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [127:0] make_alphabet(int radix);
        bit           taken[256];
        logic [7:0]   c;
        logic [127:0] syms;
        syms = {$urandom, $urandom, $urandom, $urandom};
        for (int d = 0; d < radix; d++) begin
            do c = 8'($urandom_range(32, 126));
            while (taken[c] || c == SYM_PLUS || c == SYM_MINUS);
            taken[c] = 1'b1;
            syms[d * 8 +: 8] = c;
        end
        return syms;
    endfunction

    task automatic load_random_alphabet();
        logic [127:0]          syms;
        logic [CFG_DATA_W-1:0] len_word;
        int                    radix;
        int                    pick;
        int                    i;
        flaw_t                 flaw;
        if ($urandom_range(3) == 0) begin
            radix = $urandom_range(1) ? 2 : DEF_MAX_BASE;
        end else begin
            radix = $urandom_range(2, DEF_MAX_BASE);
        end
        syms     = make_alphabet(radix);
        len_word = {$urandom, $urandom};
        len_word[BASE_LEN_W-1:0] = BASE_LEN_W'(radix);
        pick = $urandom_range(8);
        flaw = (pick < 3) ? flaw_t'(pick + 1) : FLAW_NONE;
        case (flaw)
            FLAW_BAD_SYMBOL: begin
                i = $urandom_range(radix - 1);
                case ($urandom_range(3))
                    0:       syms[i * 8 +: 8] = SYM_PLUS;
                    1:       syms[i * 8 +: 8] = SYM_MINUS;
                    2:       syms[i * 8 +: 8] = 8'($urandom_range(0, 31));
                    default: syms[i * 8 +: 8] = 8'($urandom_range(127, 255));
                endcase
            end
            FLAW_REPEAT: begin
                i = $urandom_range(1, radix - 1);
                syms[i * 8 +: 8] = syms[$urandom_range(i - 1) * 8 +: 8];
            end
            FLAW_BAD_LENGTH: begin
                len_word[BASE_LEN_W-1:0] = $urandom_range(1)
                                           ? BASE_LEN_W'($urandom_range(1))
                                           : BASE_LEN_W'($urandom_range(17, 31));
            end
            default: ;
        endcase
        load_alphabet(len_word, syms);
    endtask

    function automatic logic [NUMBER_W-1:0] next_number();
        logic [NUMBER_W-1:0] v;
        logic [NUMBER_W-1:0] p;
        int                  radix;
        radix = (radix_reg >= 2 && radix_reg <= DEF_MAX_BASE) ? int'(radix_reg) : 10;
        case ($urandom_range(5))
            0: v = $urandom_range(80) - 40;
            1: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                // Values next to a power of the radix, where the digit count changes.
                p = 1;
                repeat ($urandom_range(31)) begin
                    if (p <= 32'hFFFF_FFFF / radix) p = p * radix;
                end
                v = p - $urandom_range(1);
                if ($urandom_range(1)) v = -v;
            end
            3: begin
                case ($urandom_range(4))
                    0:       v = '0;
                    1:       v = 32'd1;
                    2:       v = '1;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_reset_decimal();
        send_idle_pct = 21;
        recv_idle_pct = 71;
        send_number(32'd0);
        send_number(32'd1);
        send_number(-32'sd1);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd9);
        send_number(32'd10);
        send_number(-32'sd10);
    endtask

    task automatic test_radix_extremes();
        logic [127:0] syms;
        hold_until_idle();
        load_alphabet(64'hFFFF_FFFF_FFFF_FFF0, HEX_SYMBOLS);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(-32'sd16);
        // Binary with the lowest and highest printable codes; the unused bytes hold a '+'
        // and junk, which must be ignored.
        hold_until_idle();
        syms = {$urandom, $urandom, $urandom, $urandom};
        syms[15:0] = {8'd126, 8'd32};
        syms[23:16] = SYM_PLUS;
        load_alphabet(64'hFFFF_FFFF_FFFF_FFE2, syms);
        send_number(32'h8000_0000);
        send_number(-32'sd1);
        send_number(32'h7FFF_FFFF);
    endtask

    task automatic try_silent(input logic [CFG_DATA_W-1:0] len_word,
                              input logic [127:0] syms);
        hold_until_idle();
        load_alphabet(len_word, syms);
        send_number($urandom);
    endtask

    task automatic test_bad_alphabets();
        logic [127:0] syms;
        try_silent(64'd0, HEX_SYMBOLS);
        try_silent(64'd1, HEX_SYMBOLS);
        try_silent(64'd17, HEX_SYMBOLS);
        try_silent(64'd31, HEX_SYMBOLS);
        syms = HEX_SYMBOLS;
        syms[127:120] = SYM_PLUS;
        try_silent(64'd16, syms);
        syms = HEX_SYMBOLS;
        syms[7:0] = SYM_MINUS;
        try_silent(64'd16, syms);
        syms = HEX_SYMBOLS;
        syms[63:56] = 8'd31;
        try_silent(64'd16, syms);
        syms = HEX_SYMBOLS;
        syms[71:64] = 8'd127;
        try_silent(64'd16, syms);
        syms = HEX_SYMBOLS;
        syms[127:120] = syms[7:0];
        try_silent(64'd16, syms);
        // A write to the unmapped index must leave the decimal alphabet untouched.
        hold_until_idle();
        write_register(REG_UNMAPPED, {$urandom, $urandom}, 1'b0);
        load_alphabet(64'd10, {16'h0000, $urandom, 16'h3938, SYMBOLS_LOW_RST});
        @(posedge aclk);
        write_register(REG_UNMAPPED, {$urandom, $urandom}, 1'b1);
        send_number(-32'sd12345);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int target);
        int start_count;
        int burst;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = printed_items;
        while (printed_items - start_count < target) begin
            hold_until_idle();
            load_random_alphabet();
            burst = alphabet_valid() ? $urandom_range(10, 35) : $urandom_range(2, 5);
            repeat (burst) send_number(next_number());
        end
    endtask

    task automatic test_output_stall();
        logic [127:0] syms;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_until_idle();
        syms = make_alphabet(2);
        load_alphabet(64'd2, syms);
        stall_cycles_left = STALL_CYCLES;
        repeat (12) send_number($urandom | 32'h8000_0000);
    endtask

    initial begin : run_tests
        int waited;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_decimal();
        test_radix_extremes();
        test_bad_alphabets();
        test_random(21, 71, 120);
        test_random(71, 21, 120);
        test_random(0, 0, 120);
        test_output_stall();
        s_valid <= 1'b0;
        waited = 0;
        while (pending_text.size() != 0 && waited < 100_000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_text.size() != 0) begin
            failures += pending_text.size();
            $display("ERROR %0d expected symbols never arrived", pending_text.size());
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d numbers (%0d negative, %0d under invalid alphabets) across %0d alphabets.",
                 items_sent, negative_items, silent_items, alphabets_seen);
        $display("Checked %0d symbols; input held off %0d cycles during the long output stall.",
                 symbols_checked, blocked_cycles);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", failures);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> signed_radix_digit_emitter.f
rtl/core/sde_pkg.sv
rtl/core/sde_front.sv
rtl/core/sde_queue.sv
rtl/core/sde_back.sv
rtl/core/signed_radix_digit_emitter.sv
tb/sv/testbench.sv
